@@ src/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker files.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define ASSERT_AT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// clocked property, switched off while rst is high
`define ASSERT_AT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ src/bb3e_pkg.sv @@
// -----------------------------------------------------------------------------
// bb3e_pkg
// Types and constants of the 3x3 edge-clipped box blur.
// -----------------------------------------------------------------------------
package bb3e_pkg;

   localparam int MAX_SIZE_DEF = 512;
   localparam int SIZE_W       = 10;
   localparam int CH_W         = 16;
   localparam int SUM_W        = 20;   // nine 16-bit taps
   localparam int RECIP_W      = 21;
   localparam int PROD_W       = SUM_W + RECIP_W;
   localparam int SHIFT_W      = 5;
   localparam int FIFO_DEPTH   = 8;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   // exact floor division for sums below 2**20
   localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(1398102);  // ceil(2**22 / 3)
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(1864136);  // ceil(2**24 / 9)
   localparam logic [SHIFT_W-1:0] SHIFT_3 = SHIFT_W'(22);
   localparam logic [SHIFT_W-1:0] SHIFT_6 = SHIFT_W'(23);
   localparam logic [SHIFT_W-1:0] SHIFT_9 = SHIFT_W'(24);

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      DIV_1,
      DIV_2,
      DIV_3,
      DIV_4,
      DIV_6,
      DIV_9
   } div_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic      frame_end;
   } result_type;

endpackage

@@ src/bb3e_ram.sv @@
// -----------------------------------------------------------------------------
// bb3e_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read at the address being written returns the old contents.
// -----------------------------------------------------------------------------
module bb3e_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;
   logic [WIDTH-1:0] q_in;

   assign q_in    = mem_ff[rd_addr];
   assign rd_data = q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      q_ff <= q_in;
   end

endmodule

@@ src/box_blur_3x3_edge_clipped_top.sv @@
// -----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_top
// Streaming 3x3 mean filter with edge clipping over a square RGB image.
// -----------------------------------------------------------------------------
// Input channel (req_*): one pixel per transfer in raster order, op = pixel.
// Once the whole frame is in, drain transfers (op = drain) push out the
// remaining results; a drain before that is dropped, a pixel after that is
// taken as a drain. Result channel (rsp_*): one filtered pixel per transfer in
// raster order, frame_end set on the last one of the frame.
// Pixel o (from 0) is output by input transfer o + size, or o + 2 at size 1.
// csr_wr_data sets the side length (0 acts as 1, clipped to MAX_SIZE) and
// restarts the frame; write it only with nothing in flight.
// Throughput: one input transfer per clock while req_stall is low. Each transfer
// reads one entry of both line memories and, when it takes a pixel, writes it
// back; same-entry back-to-back accesses are forwarded. A result goes through
// the registered window update, tap sum, reciprocal multiply and shift steps.
// Results queue in an 8-entry output FIFO; req_stall rises when the results
// in flight plus queued reach 8, so a stalled receiver backs up the input.
// Reset clears counters, window, FIFO and size (64); line memories are not
// cleared and need no clearing pass.
// -----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_top #(
   parameter int MAX_SIZE = bb3e_pkg::MAX_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bb3e_pkg::SIZE_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [bb3e_pkg::CH_W-1:0]   req_red_in,
   input  logic [bb3e_pkg::CH_W-1:0]   req_green_in,
   input  logic [bb3e_pkg::CH_W-1:0]   req_blue_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bb3e_pkg::CH_W-1:0]   rsp_red_out,
   output logic [bb3e_pkg::CH_W-1:0]   rsp_green_out,
   output logic [bb3e_pkg::CH_W-1:0]   rsp_blue_out,
   output logic                        rsp_frame_end
);

   import bb3e_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SIZE);
   localparam int CNT_W  = $clog2(MAX_SIZE + 2);
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CRD_W  = $clog2(FIFO_DEPTH + 1);
   localparam int PIX_W  = $bits(pixel_type);

   // configuration and frame position
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]  side;
   logic [CNT_W-1:0]  in_row_ff, in_row_in;
   logic [ADDR_W-1:0] in_col_ff, in_col_in;
   logic [ADDR_W-1:0] out_row_ff, out_row_in;
   logic [ADDR_W-1:0] out_col_ff, out_col_in;

   // front end decode
   logic        accept, taking, ignore, step, out_en, last;
   logic [CNT_W-1:0] in_col_nx, out_row_nx, out_col_nx;
   logic        rok0, rok2, cok0, cok2;
   logic [2:0]  rok, cok;
   logic [1:0]  nrows, ncols;
   logic [8:0]  mask;
   div_type     div;
   pixel_type   px;

   // stage 1: line memory data, window update
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_taking_ff, s1_taking_in;
   logic              s1_out_en_ff, s1_out_en_in;
   logic              s1_last_ff, s1_last_in;
   logic [8:0]        s1_mask_ff, s1_mask_in;
   div_type           s1_div_ff, s1_div_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   pixel_type         s1_pix_ff, s1_pix_in;
   pixel_type         upper_q, mid_q, upper_val, mid_val;
   logic              wr_en;
   logic              fwd_hit_ff, fwd_hit_in;
   pixel_type         fwd_upper_ff, fwd_upper_in;
   pixel_type         fwd_mid_ff, fwd_mid_in;
   pixel_type         win_ff [3][3];
   pixel_type         win_in [3][3];

   // stage 2: tap sum
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_last_ff, s2_last_in;
   logic [8:0]        s2_mask_ff, s2_mask_in;
   div_type           s2_div_ff, s2_div_in;
   logic [CH_W-1:0]   tap_ch [3][9];
   logic [SUM_W-1:0]  row_sum [3][3];

   // stage 3: reciprocal multiply
   logic              s3_valid_ff, s3_valid_in;
   logic              s3_last_ff, s3_last_in;
   div_type           s3_div_ff, s3_div_in;
   logic [SUM_W-1:0]  sum_ff [3];
   logic [SUM_W-1:0]  sum_in [3];
   logic [RECIP_W-1:0] mult;
   logic [SHIFT_W-1:0] shift;

   // stage 4: shift into the queue
   logic              s4_valid_ff, s4_valid_in;
   logic              s4_last_ff, s4_last_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [PROD_W-1:0] prod_ff [3];
   logic [PROD_W-1:0] prod_in [3];
   logic [PROD_W-1:0] quot [3];

   // output queue
   result_type        fifo_ff [FIFO_DEPTH];
   result_type        res_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CRD_W-1:0]  fcnt_ff, fcnt_in;
   logic [CRD_W-1:0]  crd_ff, crd_in;
   logic              push, pop, issue;

   // ---------------------------------------------------------------- front end
   always_comb begin
      if (size_ff == '0) begin
         side = CNT_W'(1);
      end else if (32'(size_ff) > MAX_SIZE) begin
         side = CNT_W'(MAX_SIZE);
      end else begin
         side = CNT_W'(size_ff);
      end
   end

   assign accept = req_valid && !req_stall;
   assign taking = in_row_ff < side;
   assign ignore = (req_op == OP_DRAIN) && taking;
   assign step   = accept && !ignore;

   assign in_col_nx  = CNT_W'(in_col_ff) + CNT_W'(1);
   assign out_row_nx = CNT_W'(out_row_ff) + CNT_W'(1);
   assign out_col_nx = CNT_W'(out_col_ff) + CNT_W'(1);

   assign out_en = (in_row_ff >= CNT_W'(2))
                || ((in_row_ff == CNT_W'(1)) && ((in_col_ff != '0) || (in_col_nx < side)));

   assign rok0 = out_row_ff != '0;
   assign rok2 = out_row_nx < side;
   assign cok0 = out_col_ff != '0;
   assign cok2 = out_col_nx < side;
   assign rok  = {rok2, 1'b1, rok0};
   assign cok  = {cok2, 1'b1, cok0};
   assign last = !rok2 && !cok2;

   assign nrows = {1'b0, rok0} + {1'b0, rok2};
   assign ncols = {1'b0, cok0} + {1'b0, cok2};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = rok[r] && cok[c];
         end
      end
   end

   // taps in the clipped window: (1 + nrows) * (1 + ncols)
   always_comb begin
      case ({nrows, ncols})
         4'b0000:          div = DIV_1;
         4'b0001, 4'b0100: div = DIV_2;
         4'b0010, 4'b1000: div = DIV_3;
         4'b0101:          div = DIV_4;
         4'b0110, 4'b1001: div = DIV_6;
         4'b1010:          div = DIV_9;
         default:          div = DIV_1;
      endcase
   end

   always_comb begin
      if (taking) begin
         px = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      end else begin
         px = '0;
      end
   end

   always_comb begin
      size_in    = size_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (csr_wr_en) begin
         size_in    = csr_wr_data;
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (step) begin
         if (in_col_nx >= side) begin
            in_col_in = '0;
            in_row_in = in_row_ff + CNT_W'(1);
         end else begin
            in_col_in = in_col_nx[ADDR_W-1:0];
         end
         if (out_en) begin
            if (out_col_nx >= side) begin
               out_col_in = '0;
               out_row_in = out_row_nx[ADDR_W-1:0];
            end else begin
               out_col_in = out_col_nx[ADDR_W-1:0];
            end
            if (last) begin
               in_row_in  = '0;
               in_col_in  = '0;
               out_row_in = '0;
               out_col_in = '0;
            end
         end
      end
   end

   // ------------------------------------------------------------------ stage 1
   assign s1_valid_in  = step;
   assign s1_taking_in = taking;
   assign s1_out_en_in = out_en;
   assign s1_last_in   = last;
   assign s1_mask_in   = mask;
   assign s1_div_in    = div;
   assign s1_addr_in   = in_col_ff;
   assign s1_pix_in    = px;

   assign wr_en = s1_valid_ff && s1_taking_ff;

   // the read issued this cycle misses the write-back of the item in stage 1
   assign fwd_hit_in   = wr_en && (s1_addr_ff == in_col_ff);
   assign fwd_upper_in = mid_val;
   assign fwd_mid_in   = s1_pix_ff;

   assign upper_val = fwd_hit_ff ? fwd_upper_ff : upper_q;
   assign mid_val   = fwd_hit_ff ? fwd_mid_ff   : mid_q;

   bb3e_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIZE)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_val),
      .rd_addr (in_col_ff),
      .rd_data (upper_q)
   );

   bb3e_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIZE)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (in_col_ff),
      .rd_data (mid_q)
   );

   always_comb begin
      win_in = win_ff;
      if (csr_wr_en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_in[r][c] = '0;
            end
         end
      end else if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = upper_val;
         win_in[1][2] = mid_val;
         win_in[2][2] = s1_pix_ff;
      end
   end

   // ------------------------------------------------------------------ stage 2
   assign s2_valid_in = s1_valid_ff && s1_out_en_ff;
   assign s2_last_in  = s1_last_ff;
   assign s2_mask_in  = s1_mask_ff;
   assign s2_div_in   = s1_div_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (s2_mask_ff[r*3+c]) begin
               tap_ch[0][r*3+c] = win_ff[r][c].red;
               tap_ch[1][r*3+c] = win_ff[r][c].green;
               tap_ch[2][r*3+c] = win_ff[r][c].blue;
            end else begin
               tap_ch[0][r*3+c] = '0;
               tap_ch[1][r*3+c] = '0;
               tap_ch[2][r*3+c] = '0;
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            row_sum[k][r] = SUM_W'(tap_ch[k][r*3]) + SUM_W'(tap_ch[k][r*3+1])
                          + SUM_W'(tap_ch[k][r*3+2]);
         end
         sum_in[k] = row_sum[k][0] + row_sum[k][1] + row_sum[k][2];
      end
   end

   // ------------------------------------------------------------------ stage 3
   assign s3_valid_in = s2_valid_ff;
   assign s3_last_in  = s2_last_ff;
   assign s3_div_in   = s2_div_ff;

   always_comb begin
      case (s3_div_ff)
         DIV_1: begin
            mult  = RECIP_W'(1);
            shift = SHIFT_W'(0);
         end
         DIV_2: begin
            mult  = RECIP_W'(1);
            shift = SHIFT_W'(1);
         end
         DIV_4: begin
            mult  = RECIP_W'(1);
            shift = SHIFT_W'(2);
         end
         DIV_3: begin
            mult  = RECIP_3;
            shift = SHIFT_3;
         end
         DIV_6: begin
            mult  = RECIP_3;
            shift = SHIFT_6;
         end
         DIV_9: begin
            mult  = RECIP_9;
            shift = SHIFT_9;
         end
         default: begin
            mult  = RECIP_W'(1);
            shift = SHIFT_W'(0);
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PROD_W'(sum_ff[k]) * PROD_W'(mult);
      end
   end

   assign s4_valid_in = s3_valid_ff;
   assign s4_last_in  = s3_last_ff;
   assign shift_in    = shift;

   // ------------------------------------------------------------------ stage 4
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         quot[k] = prod_ff[k] >> shift_ff;
      end
   end

   assign res_in.pix.red   = quot[0][CH_W-1:0];
   assign res_in.pix.green = quot[1][CH_W-1:0];
   assign res_in.pix.blue  = quot[2][CH_W-1:0];
   assign res_in.frame_end = s4_last_ff;

   // ------------------------------------------------------------- output queue
   assign push  = s4_valid_ff;
   assign pop   = rsp_valid && !rsp_stall;
   assign issue = step && out_en;

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign fcnt_in   = fcnt_ff + CRD_W'(push) - CRD_W'(pop);
   // credits cover every result between acceptance and the receiver
   assign crd_in    = crd_ff + CRD_W'(issue) - CRD_W'(pop);

   assign req_stall     = crd_ff == CRD_W'(FIFO_DEPTH);
   assign rsp_valid     = fcnt_ff != '0;
   assign rsp_red_out   = fifo_ff[rd_ptr_ff].pix.red;
   assign rsp_green_out = fifo_ff[rd_ptr_ff].pix.green;
   assign rsp_blue_out  = fifo_ff[rd_ptr_ff].pix.blue;
   assign rsp_frame_end = fifo_ff[rd_ptr_ff].frame_end;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_RESET;
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fcnt_ff     <= '0;
         crd_ff      <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         size_ff     <= size_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fcnt_ff     <= fcnt_in;
         crd_ff      <= crd_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_taking_ff <= s1_taking_in;
      s1_out_en_ff <= s1_out_en_in;
      s1_last_ff   <= s1_last_in;
      s1_mask_ff   <= s1_mask_in;
      s1_div_ff    <= s1_div_in;
      s1_addr_ff   <= s1_addr_in;
      s1_pix_ff    <= s1_pix_in;
      fwd_upper_ff <= fwd_upper_in;
      fwd_mid_ff   <= fwd_mid_in;
      s2_last_ff   <= s2_last_in;
      s2_mask_ff   <= s2_mask_in;
      s2_div_ff    <= s2_div_in;
      s3_last_ff   <= s3_last_in;
      s3_div_ff    <= s3_div_in;
      sum_ff       <= sum_in;
      s4_last_ff   <= s4_last_in;
      shift_ff     <= shift_in;
      prod_ff      <= prod_in;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res_in;
      end
   end

endmodule

@@ src/bb3e_checker.sv @@
// -----------------------------------------------------------------------------
// bb3e_checker
// Port-level assertions for the box blur top, attached by bind.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bb3e_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [bb3e_pkg::CH_W-1:0] rsp_red_out,
   input logic [bb3e_pkg::CH_W-1:0] rsp_green_out,
   input logic [bb3e_pkg::CH_W-1:0] rsp_blue_out,
   input logic                      rsp_frame_end
);

   // a stalled result must be held
   `ASSERT_AT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_end), "result changed while stalled")

   // pipeline is at least four deep, so nothing comes out right after reset
   `ASSERT_AT(a_rst_quiet, clock, reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid, "result too soon after reset")

   // credits start empty
   `ASSERT_AT(a_rst_ready, clock, reset |=> !req_stall, "input stalled right after reset")

endmodule

bind box_blur_3x3_edge_clipped_top bb3e_checker u_bb3e_checker (.*);

@@ tb/box_blur_checker.sv @@
// -----------------------------------------------------------------------------
// blur_stream_checker
// Watches the pixel and result channels of the 3x3 box blur, keeps its own
// copy of line stores, window and counters, and compares every result
// transfer against the predicted filtered pixel.
// -----------------------------------------------------------------------------
module blur_stream_checker #(
   parameter int MAX_SIDE = bb3e_pkg::MAX_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bb3e_pkg::SIZE_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_op,
   input  logic [bb3e_pkg::CH_W-1:0]   req_red_in,
   input  logic [bb3e_pkg::CH_W-1:0]   req_green_in,
   input  logic [bb3e_pkg::CH_W-1:0]   req_blue_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [bb3e_pkg::CH_W-1:0]   rsp_red_out,
   input  logic [bb3e_pkg::CH_W-1:0]   rsp_green_out,
   input  logic [bb3e_pkg::CH_W-1:0]   rsp_blue_out,
   input  logic                        rsp_frame_end,
   output int                          error_count,
   output int                          pending,
   output int                          results_seen
);

   import bb3e_pkg::*;

   pixel_type         upper_row [MAX_SIDE];
   pixel_type         middle_row [MAX_SIDE];
   pixel_type         win [3][3];
   int unsigned       in_row, in_col, out_row, out_col;
   logic [SIZE_W-1:0] side_reg;
   result_type        expected_pixels [$];

   initial begin
      error_count  = 0;
      pending      = 0;
      results_seen = 0;
      side_reg     = SIZE_RESET;
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
   end

   function automatic int unsigned frame_side();
      if (side_reg == '0) return 1;
      if (int'(side_reg) > MAX_SIDE) return MAX_SIDE;
      return side_reg;
   endfunction

   task automatic restart_frame();
      foreach (win[r, c]) win[r][c] = '0;
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
   endtask

   // one accepted input transfer: shift window, update line stores, maybe emit
   task automatic blur_step(input op_type op, input pixel_type src);
      int unsigned n, ri, ci, cnt;
      int unsigned sum_r, sum_g, sum_b;
      bit          taking, last;
      bit          rok [3];
      bit          cok [3];
      pixel_type   px;
      result_type  res;
      n      = frame_side();
      taking = in_row < n;
      ri     = in_row;
      ci     = in_col;
      if (op == OP_DRAIN && taking) return;     // early drain is dropped
      px = taking ? src : '0;                   // surplus pixel acts as drain
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = upper_row[ci];
      win[1][2] = middle_row[ci];
      win[2][2] = px;
      if (taking) begin
         upper_row[ci]  = middle_row[ci];
         middle_row[ci] = px;
      end
      in_col++;
      if (in_col >= n) begin
         in_col = 0;
         in_row++;
      end
      if (!(ri >= 2 || (ri == 1 && in_col != 0) || (ri == 1 && ci >= 1))) return;

      rok[0] = out_row >= 1;
      rok[1] = 1'b1;
      rok[2] = out_row + 1 < n;
      cok[0] = out_col >= 1;
      cok[1] = 1'b1;
      cok[2] = out_col + 1 < n;
      sum_r  = 0;
      sum_g  = 0;
      sum_b  = 0;
      cnt    = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (rok[r] && cok[c]) begin
               sum_r += win[r][c].red;
               sum_g += win[r][c].green;
               sum_b += win[r][c].blue;
               cnt++;
            end
         end
      end
      res.pix.red   = CH_W'(sum_r / cnt);
      res.pix.green = CH_W'(sum_g / cnt);
      res.pix.blue  = CH_W'(sum_b / cnt);
      last          = (out_row + 1 >= n) && (out_col + 1 >= n);
      res.frame_end = last;
      expected_pixels.push_back(res);

      out_col++;
      if (out_col >= n) begin
         out_col = 0;
         out_row++;
      end
      if (last) begin
         in_row  = 0;
         in_col  = 0;
         out_row = 0;
         out_col = 0;
      end
   endtask

   task automatic check_field(input string what, input logic [CH_W-1:0] want,
                              input logic [CH_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         side_reg = SIZE_RESET;
         restart_frame();
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got %h %h %h end=%b",
                        $time, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end);
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.pix.red, rsp_red_out);
               check_field("green", want.pix.green, rsp_green_out);
               check_field("blue", want.pix.blue, rsp_blue_out);
               check_field("frame_end", CH_W'(want.frame_end), CH_W'(rsp_frame_end));
            end
         end
         if (csr_wr_en) begin
            side_reg = csr_wr_data;
            restart_frame();
         end
         if (req_valid && !req_stall)
            blur_step(op_type'(req_op), pixel_type'({req_red_in, req_green_in, req_blue_in}));
      end
      pending = expected_pixels.size();
   end

endmodule

@@ tb/box_blur_3x3_edge_clipped_top_test.sv @@
// -----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_top_test
// Drives pixel frames of many sizes through the 3x3 box blur with random
// idling on both channels and lets blur_stream_checker judge every result.
// -----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_top_test;
   import bb3e_pkg::*;

   localparam int LOOP_ITEMS    = 760;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int LONG_HOLD     = 200;
   localparam int SETTLE_CYCLES = 12;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   logic              req_valid;
   logic              req_stall;
   logic              req_op;
   logic [CH_W-1:0]   req_red_in;
   logic [CH_W-1:0]   req_green_in;
   logic [CH_W-1:0]   req_blue_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CH_W-1:0]   rsp_red_out;
   logic [CH_W-1:0]   rsp_green_out;
   logic [CH_W-1:0]   rsp_blue_out;
   logic              rsp_frame_end;

   int error_count, pending, results_seen;
   int cycle_count  = 0;
   int transfers    = 0;
   int size_writes  = 0;
   bit quiet        = 1'b0;   // no idling at all in the closing part
   bit calm         = 1'b0;   // phase-wide stretch with no idling
   bit hold_output  = 1'b0;   // asks the receiver for one long hold-off

   box_blur_3x3_edge_clipped_top DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   blur_stream_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end),
      .error_count   (error_count),
      .pending       (pending),
      .results_seen  (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stall bursts plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_output = 1'b0;
         end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic pixel_type pick_pixel();
      pixel_type p;
      case ($urandom_range(0, 7))
         0: p = '0;
         1: p = '1;
         2: begin
            p.red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         default: p = {CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
      endcase
      return p;
   endfunction

   function automatic int unsigned pick_side();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 3;
         8: return $urandom_range(10, 14);
         9: return $urandom_range(15, 20);
         default: return $urandom_range(4, 9);
      endcase
   endfunction

   function automatic int unsigned eff_side(input int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_SIZE_DEF) return MAX_SIZE_DEF;
      return v;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input op_type op, input pixel_type p);
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_red_in   <= p.red;
      req_green_in <= p.green;
      req_blue_in  <= p.blue;
      do @(posedge clock); while (req_stall);
      transfers++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] v);
      wait_drained();
      // transfers that give no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      size_writes++;
   endtask

   // full frame, n*n pixels then n+1 drain ticks; noisy adds dropped early drains
   task automatic send_frame(input int unsigned n, input bit noisy, input bit pause_mid);
      for (int unsigned i = 0; i < n * n; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) send_item(OP_DRAIN, pick_pixel());
         if (pause_mid && i == n * n / 2) wait_drained();
         send_item(OP_PIXEL, pick_pixel());
      end
      for (int unsigned i = 0; i <= n; i++)
         send_item(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN, pick_pixel());
   endtask

   // frame cut short; the next size write restarts it
   task automatic send_partial(input int unsigned n, input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_item((i < n * n) ? OP_PIXEL : OP_DRAIN, pick_pixel());
   endtask

   initial begin
      int unsigned side, n, phase;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_valid    = 1'b0;
      req_op       = OP_PIXEL;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // size 1: early drain dropped, surplus pixel drains silently, drain closes
      write_size(SIZE_W'(1));
      send_item(OP_DRAIN, '1);
      send_item(OP_PIXEL, '1);
      send_item(OP_PIXEL, '0);
      send_item(OP_DRAIN, '0);
      // zero behaves as size 1
      write_size(SIZE_W'(0));
      send_item(OP_PIXEL, {16'h8001, 16'h7FFE, 16'h00FF});
      send_item(OP_DRAIN, '0);
      send_item(OP_DRAIN, '0);
      // size 2: every output is a corner
      write_size(SIZE_W'(2));
      send_item(OP_PIXEL, '1);
      send_item(OP_PIXEL, '0);
      send_item(OP_PIXEL, '1);
      send_item(OP_PIXEL, {16'hFFFF, 16'h0001, 16'h8000});
      repeat (3) send_item(OP_DRAIN, '0);
      // size 3: full-scale sums around a zero center, divisors 9, 6 and 4
      write_size(SIZE_W'(3));
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_item(OP_PIXEL, '0);
         else send_item(OP_PIXEL, '1);
      end
      repeat (4) send_item(OP_DRAIN, '0);

      phase = 0;
      while (transfers < LOOP_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         case (phase)
            0: begin
               write_size(SIZE_W'(6));
               hold_output = 1'b1;
               send_frame(6, 1'b1, 1'b0);
            end
            1: begin
               // above the maximum: acts as the maximum side
               write_size(SIZE_W'(1023));
               send_partial(MAX_SIZE_DEF, MAX_SIZE_DEF + 11);
            end
            2: begin
               write_size(SIZE_W'(7));
               send_frame(7, 1'b0, 1'b1);
            end
            default: begin
               side = pick_side();
               n    = eff_side(side);
               // keep the tail of the loop close to the item budget
               if (transfers + 3 * n * (n + 1) > LOOP_ITEMS) begin
                  side = 2;
                  n    = 2;
               end
               write_size(SIZE_W'(side));
               if ($urandom_range(0, 7) == 0) begin
                  send_partial(n, $urandom_range(1, n * n + n));
               end else begin
                  repeat ($urandom_range(1, 3)) begin
                     send_frame(n, $urandom_range(0, 1), 1'b0);
                     if ($urandom_range(0, 3) == 0) send_item(OP_DRAIN, pick_pixel());
                  end
               end
            end
         endcase
         phase++;
      end

      quiet = 1'b1;
      calm  = 1'b0;
      write_size(SIZE_W'(4));
      send_frame(4, 1'b0, 1'b0);
      write_size(SIZE_W'(5));
      send_frame(5, 1'b1, 1'b0);

      wait_drained();
      repeat (20) @(negedge clock);

      $display("Sent %0d transfers over %0d size settings (0, 1 and 1023 among them);",
               transfers, size_writes);
      $display("checked %0d filtered pixels against the predicted means.", results_seen);
      if (error_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
